// ===== design/msq_pkg.sv =====
// msq_pkg: shared types, codes and helper functions for the marching squares
// cell segment generator
// no dependencies
package msq_pkg;

  // fixed coordinate format: signed 32-bit fixed point
  localparam int COORD_W    = 32;
  localparam int STEP_W     = 31;
  localparam int EDGE_FRAC  = 16;
  localparam int DIV_STAGES = 4;
  localparam int DIV_BPS    = EDGE_FRAC / DIV_STAGES;
  localparam int NUM_EDGES  = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic [EDGE_FRAC-1:0]      frac_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_LEVEL    = 3'd0,
    CFG_WIDTH    = 3'd1,
    CFG_HEIGHT   = 3'd2,
    CFG_POSITION = 3'd3,
    CFG_AXIS     = 3'd4
  } cfg_idx_e;

  // section axis codes
  typedef enum logic [1:0] {
    AXIS_X  = 2'd0,
    AXIS_Y  = 2'd1,
    AXIS_Z  = 2'd2,
    AXIS_Z3 = 2'd3
  } axis_e;

  // crossing point codes: bottom, left, top, right edge
  typedef enum logic [1:0] {
    PT_BOTTOM = 2'd0,
    PT_LEFT   = 2'd1,
    PT_TOP    = 2'd2,
    PT_RIGHT  = 2'd3
  } pt_e;

  typedef struct packed {
    logic [1:0] count;
    pt_e        s0;
    pt_e        e0;
    pt_e        s1;
    pt_e        e1;
  } seg_plan_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point3_t;

  // per-cell context carried down the pipeline
  typedef struct packed {
    logic [3:0] pat;
    coord_t     x;
    coord_t     y;
    coord_t     xw;
    coord_t     yh;
    logic       sad_ge;
    logic       sad_le;
  } ctx_t;

  // add a non-negative offset and clamp to the signed 32-bit range
  function automatic coord_t sat_add(coord_t p, step_t off);
    logic signed [COORD_W:0] sum;
    sum = {p[COORD_W-1], p} + $signed({2'b00, off});
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
    return sum[COORD_W-1:0];
  endfunction

  // segment endpoints by sign pattern; saddles resolved by centre sign
  function automatic seg_plan_t seg_plan(logic [3:0] pat, logic ge, logic le);
    seg_plan_t p;
    p = '{count: 2'd1, s0: PT_BOTTOM, e0: PT_BOTTOM, s1: PT_BOTTOM, e1: PT_BOTTOM};
    case (pat)
      4'd1:  begin p.s0 = PT_BOTTOM; p.e0 = PT_LEFT;   end
      4'd2:  begin p.s0 = PT_LEFT;   p.e0 = PT_TOP;    end
      4'd3:  begin p.s0 = PT_BOTTOM; p.e0 = PT_TOP;    end
      4'd4:  begin p.s0 = PT_TOP;    p.e0 = PT_RIGHT;  end
      4'd6:  begin p.s0 = PT_LEFT;   p.e0 = PT_RIGHT;  end
      4'd7:  begin p.s0 = PT_BOTTOM; p.e0 = PT_RIGHT;  end
      4'd8:  begin p.s0 = PT_RIGHT;  p.e0 = PT_BOTTOM; end
      4'd9:  begin p.s0 = PT_RIGHT;  p.e0 = PT_LEFT;   end
      4'd11: begin p.s0 = PT_RIGHT;  p.e0 = PT_TOP;    end
      4'd12: begin p.s0 = PT_TOP;    p.e0 = PT_BOTTOM; end
      4'd13: begin p.s0 = PT_TOP;    p.e0 = PT_LEFT;   end
      4'd14: begin p.s0 = PT_LEFT;   p.e0 = PT_BOTTOM; end
      4'd10: begin
        p.count = 2'd2;
        if (ge) begin
          p.s0 = PT_RIGHT; p.e0 = PT_BOTTOM; p.s1 = PT_LEFT; p.e1 = PT_TOP;
        end else begin
          p.s0 = PT_LEFT; p.e0 = PT_BOTTOM; p.s1 = PT_RIGHT; p.e1 = PT_TOP;
        end
      end
      4'd5: begin
        p.count = 2'd2;
        if (le) begin
          p.s0 = PT_BOTTOM; p.e0 = PT_LEFT; p.s1 = PT_TOP; p.e1 = PT_RIGHT;
        end else begin
          p.s0 = PT_BOTTOM; p.e0 = PT_RIGHT; p.s1 = PT_TOP; p.e1 = PT_LEFT;
        end
      end
      default: p.count = 2'd0;
    endcase
    return p;
  endfunction

  // place a 2-D point into 3-D by section axis
  function automatic point3_t place(coord_t first, coord_t second, coord_t pos,
                                    axis_e axis);
    point3_t o;
    case (axis)
      AXIS_X:  o = '{x: pos, y: first, z: second};
      AXIS_Y:  o = '{x: second, y: pos, z: first};
      default: o = '{x: first, y: second, z: pos};
    endcase
    return o;
  endfunction

endpackage

// ===== design/msq_if.sv =====
// msq channel interfaces: cell input, segment output, configuration writes
// depends on nothing but the SAMPLE_BITS parameter of the cell channel
interface msq_cell_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] corner_low_low;
  logic signed [SAMPLE_BITS-1:0] corner_low_high;
  logic signed [SAMPLE_BITS-1:0] corner_high_high;
  logic signed [SAMPLE_BITS-1:0] corner_high_low;
  logic signed [31:0]            origin_first;
  logic signed [31:0]            origin_second;

  modport source(output valid, corner_low_low, corner_low_high, corner_high_high,
                 corner_high_low, origin_first, origin_second, input ready);
  modport sink(input valid, corner_low_low, corner_low_high, corner_high_high,
               corner_high_low, origin_first, origin_second, output ready);
endinterface

interface msq_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic               last_segment;

  modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 last_segment, input ready);
  modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z,
               last_segment, output ready);
endinterface

interface msq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [31:0] wdata;

  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface

// ===== design/marching_squares_cell_segments.sv =====
// marching_squares_cell_segments: pipelined marching squares segment generator
// depends on msq_pkg and the interfaces in msq_if.sv
//
// usage:
//   in_ch  takes one cell per transfer: four corner samples and the origin.
//   out_ch gives 0, 1 or 2 segments per cell in cell order; last_segment
//          marks the final segment of a cell. cells without a crossing give
//          no transfer at all.
//   cfg_ch writes one register per transfer (always ready); write only while
//          the pipeline is empty.
// stages: the transfer edge loads the operand stage, then the sum/product
//   stage, four divider stages of 4 quotient bits each, multiply stage,
//   saturate stage, output register.
// throughput: one cell per cycle while out_ch does not stall; a two-segment
//   cell holds the output register until both segments are taken, during which no cell moves.
// the whole pipeline advances on one enable: when out_ch stalls, in_ready
//   drops and every stage holds. reset clears all valid bits and loads the
//   register reset values.
module marching_squares_cell_segments
  import msq_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  msq_cell_if.sink   in_ch,
  msq_seg_if.source  out_ch,
  msq_cfg_if.sink    cfg_ch
);

  localparam int SB    = SAMPLE_BITS;
  localparam int DEN_W = SAMPLE_BITS + 1;

  // configuration registers
  logic signed [SB-1:0] level_r;
  step_t                width_r;
  step_t                height_r;
  coord_t               position_r;
  axis_e                axis_r;

  assign cfg_ch.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      width_r    <= step_t'(1) << COORD_FRAC_BITS;
      height_r   <= step_t'(1) << COORD_FRAC_BITS;
      position_r <= '0;
      axis_r     <= AXIS_Z;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_e'(cfg_ch.reg_index))
        CFG_LEVEL:    level_r    <= cfg_ch.wdata[SB-1:0];
        CFG_WIDTH:    width_r    <= cfg_ch.wdata[STEP_W-1:0];
        CFG_HEIGHT:   height_r   <= cfg_ch.wdata[STEP_W-1:0];
        CFG_POSITION: position_r <= cfg_ch.wdata;
        CFG_AXIS:     axis_r     <= axis_e'(cfg_ch.wdata[1:0]);
        default: ;
      endcase
    end
  end

  // pipeline enable
  logic out_valid_r;
  logic two_r;
  logic sel_r;
  logic out_last;
  logic en;

  assign out_last    = !two_r || sel_r;
  assign en          = !out_valid_r || (out_ch.ready && out_last);
  assign in_ch.ready = en;

  // operand stage: level subtract, zero fix, sign and magnitude
  logic signed [DEN_W-1:0] diff [NUM_EDGES];
  logic [SB-1:0]           samp_mag [NUM_EDGES];
  logic [3:0]              pat_nxt;
  logic signed [SB-1:0]    corner [NUM_EDGES];

  assign corner[0] = in_ch.corner_low_low;
  assign corner[1] = in_ch.corner_low_high;
  assign corner[2] = in_ch.corner_high_high;
  assign corner[3] = in_ch.corner_high_low;

  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      diff[i] = {corner[i][SB-1], corner[i]} - {level_r[SB-1], level_r};
      if (diff[i] == '0) begin
        diff[i] = DEN_W'(1);
      end
      pat_nxt[i]  = diff[i][DEN_W-1];
      samp_mag[i] = diff[i][DEN_W-1] ? SB'(-diff[i]) : SB'(diff[i]);
    end
  end

  logic          va_r;
  logic [SB-1:0] mag_a_r [NUM_EDGES];
  logic [3:0]    pat_a_r;
  coord_t        x_a_r;
  coord_t        y_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r <= samp_mag;
      pat_a_r <= pat_nxt;
      x_a_r   <= in_ch.origin_first;
      y_a_r   <= in_ch.origin_second;
    end
  end

  // sum/product stage; edges: bottom (f00,f10), left (f00,f01),
  // top (f01,f11), right (f10,f11)
  logic [DEN_W-1:0] rem_r [DIV_STAGES+1][NUM_EDGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES+1][NUM_EDGES];
  frac_t            q_r   [DIV_STAGES+1][NUM_EDGES];
  ctx_t             ctx_r [DIV_STAGES+1];
  logic             vd_r  [DIV_STAGES+1];
  logic [2*SB-1:0]  p1_r;
  logic [2*SB-1:0]  p2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0][PT_BOTTOM] <= DEN_W'(mag_a_r[0]);
      rem_r[0][PT_LEFT]   <= DEN_W'(mag_a_r[0]);
      rem_r[0][PT_TOP]    <= DEN_W'(mag_a_r[1]);
      rem_r[0][PT_RIGHT]  <= DEN_W'(mag_a_r[3]);
      den_r[0][PT_BOTTOM] <= DEN_W'(mag_a_r[0]) + DEN_W'(mag_a_r[3]);
      den_r[0][PT_LEFT]   <= DEN_W'(mag_a_r[0]) + DEN_W'(mag_a_r[1]);
      den_r[0][PT_TOP]    <= DEN_W'(mag_a_r[1]) + DEN_W'(mag_a_r[2]);
      den_r[0][PT_RIGHT]  <= DEN_W'(mag_a_r[3]) + DEN_W'(mag_a_r[2]);
      for (int e = 0; e < NUM_EDGES; e++) begin
        q_r[0][e] <= '0;
      end
      p1_r <= (2*SB)'(mag_a_r[0]) * (2*SB)'(mag_a_r[2]);
      p2_r <= (2*SB)'(mag_a_r[1]) * (2*SB)'(mag_a_r[3]);
      ctx_r[0] <= '{pat: pat_a_r, x: x_a_r, y: y_a_r,
                    xw: sat_add(x_a_r, width_r), yh: sat_add(y_a_r, height_r),
                    sad_ge: 1'b0, sad_le: 1'b0};
    end
  end

  // divider stages: restoring division, DIV_BPS quotient bits per stage
  logic [DEN_W-1:0] rem_nxt [1:DIV_STAGES][NUM_EDGES];
  frac_t            q_nxt   [1:DIV_STAGES][NUM_EDGES];

  always_comb begin
    logic [DEN_W:0]   t;
    logic [DEN_W-1:0] r;
    frac_t            q;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      for (int e = 0; e < NUM_EDGES; e++) begin
        r = rem_r[k-1][e];
        q = q_r[k-1][e];
        for (int b = 0; b < DIV_BPS; b++) begin
          t = {r, 1'b0};
          if (t >= {1'b0, den_r[k-1][e]}) begin
            r = DEN_W'(t - {1'b0, den_r[k-1][e]});
            q = {q[EDGE_FRAC-2:0], 1'b1};
          end else begin
            r = t[DEN_W-1:0];
            q = {q[EDGE_FRAC-2:0], 1'b0};
          end
        end
        rem_nxt[k][e] = r;
        q_nxt[k][e]   = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= DIV_STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        den_r[k] <= den_r[k-1];
      end
      for (int k = 2; k <= DIV_STAGES; k++) begin
        ctx_r[k] <= ctx_r[k-1];
      end
      // saddle centre sign from the registered products
      ctx_r[1] <= '{pat: ctx_r[0].pat, x: ctx_r[0].x, y: ctx_r[0].y,
                    xw: ctx_r[0].xw, yh: ctx_r[0].yh,
                    sad_ge: (p1_r >= p2_r), sad_le: (p1_r <= p2_r)};
    end
  end

  // valid bits through the sum/product and divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else if (en) begin
      vd_r[0] <= va_r;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
    end
  end

  // multiply stage: offset = (step * fraction) >> EDGE_FRAC
  logic  vm_r;
  step_t off_r [NUM_EDGES];
  ctx_t  ctx_m_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < NUM_EDGES; e++) begin
        off_r[e] <= STEP_W'((((STEP_W+EDGE_FRAC)'((e % 2 == 0) ? width_r : height_r))
                    * (STEP_W+EDGE_FRAC)'(q_r[DIV_STAGES][e])) >> EDGE_FRAC);
      end
      ctx_m_r <= ctx_r[DIV_STAGES];
    end
  end

  // saturate stage: crossing coordinates
  logic   vs_r;
  coord_t crd_r [NUM_EDGES];
  ctx_t   ctx_s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      crd_r[PT_BOTTOM] <= sat_add(ctx_m_r.x, off_r[PT_BOTTOM]);
      crd_r[PT_LEFT]   <= sat_add(ctx_m_r.y, off_r[PT_LEFT]);
      crd_r[PT_TOP]    <= sat_add(ctx_m_r.x, off_r[PT_TOP]);
      crd_r[PT_RIGHT]  <= sat_add(ctx_m_r.y, off_r[PT_RIGHT]);
      ctx_s_r          <= ctx_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vs_r <= 1'b0;
    end else if (en) begin
      vm_r <= vd_r[DIV_STAGES];
      vs_r <= vm_r;
    end
  end

  // endpoint selection and 3-D placement
  coord_t    px [NUM_EDGES];
  coord_t    py [NUM_EDGES];
  seg_plan_t plan;
  point3_t   s0_nxt;
  point3_t   e0_nxt;
  point3_t   s1_nxt;
  point3_t   e1_nxt;

  always_comb begin
    px[PT_BOTTOM] = crd_r[PT_BOTTOM];
    py[PT_BOTTOM] = ctx_s_r.y;
    px[PT_LEFT]   = ctx_s_r.x;
    py[PT_LEFT]   = crd_r[PT_LEFT];
    px[PT_TOP]    = crd_r[PT_TOP];
    py[PT_TOP]    = ctx_s_r.yh;
    px[PT_RIGHT]  = ctx_s_r.xw;
    py[PT_RIGHT]  = crd_r[PT_RIGHT];
    plan   = seg_plan(ctx_s_r.pat, ctx_s_r.sad_ge, ctx_s_r.sad_le);
    s0_nxt = place(px[plan.s0], py[plan.s0], position_r, axis_r);
    e0_nxt = place(px[plan.e0], py[plan.e0], position_r, axis_r);
    s1_nxt = place(px[plan.s1], py[plan.s1], position_r, axis_r);
    e1_nxt = place(px[plan.e1], py[plan.e1], position_r, axis_r);
  end

  // output register holding both segments of a cell
  point3_t s0_r;
  point3_t e0_r;
  point3_t s1_r;
  point3_t e1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      two_r       <= 1'b0;
      sel_r       <= 1'b0;
    end else if (en) begin
      out_valid_r <= vs_r && (plan.count != 2'd0);
      two_r       <= (plan.count == 2'd2);
      sel_r       <= 1'b0;
    end else if (out_ch.ready) begin
      // first of two segments taken
      sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
      e0_r <= e0_nxt;
      s1_r <= s1_nxt;
      e1_r <= e1_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.start_x      = sel_r ? s1_r.x : s0_r.x;
  assign out_ch.start_y      = sel_r ? s1_r.y : s0_r.y;
  assign out_ch.start_z      = sel_r ? s1_r.z : s0_r.z;
  assign out_ch.end_x        = sel_r ? e1_r.x : e0_r.x;
  assign out_ch.end_y        = sel_r ? e1_r.y : e0_r.y;
  assign out_ch.end_z        = sel_r ? e1_r.z : e0_r.z;
  assign out_ch.last_segment = out_last;

endmodule

// ===== design/msq_checker.sv =====
// msq_checker: port-level checks of the segment generator over time
// bound to marching_squares_cell_segments; no package dependency
module msq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_start_x,
  input logic        out_last
);

  // a stalled segment stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("segment dropped while stalled");

  // a stalled segment keeps its start_x and last_segment flag
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_start_x) && $stable(out_last))
    else $error("segment payload changed while stalled");

  // first of two segments is followed at once by the second
  a_second_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("second segment of a cell missing");

  // input is held off while the output stalls
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("cell taken while output stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("segment offered after reset");

endmodule

bind marching_squares_cell_segments msq_checker u_msq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_start_x (out_ch.start_x),
  .out_last    (out_ch.last_segment)
);
